>>> design/imhq_pkg.sv
`timescale 1ns / 1ps
// imhq_pkg: shared types and codes for the indexed min-heap queue
// depends on nothing; imported by indexed_min_heap_queue

package imhq_pkg;

	// command codes
	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_SET_KEY = 2'd1,
		CMD_DEL_MIN = 2'd2,
		CMD_REMOVE  = 2'd3
	} cmd_t;

	// status codes
	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_FULL      = 3'd1,
		STS_DUPLICATE = 3'd2,
		STS_NOT_FOUND = 3'd3,
		STS_EMPTY     = 3'd4
	} status_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_SK_RD,
		S_DM_RD,
		S_RM_RD,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CH,
		S_DN_CMP,
		S_FIN,
		S_RESP
	} state_t;

	// request payload
	typedef struct packed {
		cmd_t               command;
		logic [7:0]         id;
		logic signed [31:0] key;
		logic [31:0]        payload;
	} req_t;

	// result payload
	typedef struct packed {
		status_t            status;
		logic [7:0]         out_id;
		logic signed [31:0] out_key;
		logic [31:0]        out_payload;
	} res_t;

endpackage

>>> design/imhq_key_cmp.sv
`timescale 1ns / 1ps
// imhq_key_cmp: the one signed key comparator shared by every sift step
// no dependencies

module imhq_key_cmp (
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic               gt
);

	// two's complement greater-than
	assign gt = (a > b);

endmodule

>>> design/imhq_heap_ram.sv
`timescale 1ns / 1ps
// imhq_heap_ram: heap slot storage, one write port and two registered read ports
// no dependencies

module imhq_heap_ram #(
	parameter int DEPTH  = 257,
	parameter int ADDR_W = 9,
	parameter int DATA_W = 72
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> design/imhq_map_ram.sv
`timescale 1ns / 1ps
// imhq_map_ram: id-to-slot map, one write port and one registered read port
// no dependencies

module imhq_map_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> design/indexed_min_heap_queue.sv
`timescale 1ns / 1ps
// indexed_min_heap_queue: top level, command sequencer and datapath registers
// depends on imhq_pkg, imhq_heap_ram, imhq_map_ram, imhq_key_cmp
//
// Usage:
//   A request (req_valid/req_ready) carries a command, an id, a key and a
//   payload: insert, set_key, delete_min or remove by id. Every request gives
//   exactly one result (res_valid/res_ready) with a status and, for a
//   successful delete_min or remove, the id, key and payload taken out.
//   One request is handled at a time; req_ready is high only while idle.
//   The id map is looked up first, then the heap is sifted. A sift-up level
//   reads the parent and compares; a sift-down level reads the children,
//   picks a child and compares, each level paced by the single shared key
//   comparator and the registered heap memory reads. Error cases go from
//   the lookup straight to the result.
//   After reset the id map is cleared one entry per cycle, all 2**ID_BITS
//   entries (256 by default), and req_ready stays low until that pass ends.
//   The result is held in an output register; while the receiver stalls it
//   stays there and no new request is taken.

module indexed_min_heap_queue
	import imhq_pkg::*;
#(
	parameter int CAPACITY = 256,
	parameter int ID_BITS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int SLOT_W = $clog2(CAPACITY + 1);
	localparam int ENT_W  = 64 + ID_BITS;

	state_t state_q, state_d;

	logic [SLOT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0]  pos_q;
	logic [SLOT_W-1:0]  csel_q;
	logic [ID_BITS-1:0] clr_q;
	cmd_t               cmd_q;
	logic signed [31:0] cur_key_q;
	logic [ID_BITS-1:0] cur_id_q;
	logic [31:0]        cur_pay_q;
	logic signed [31:0] ch_key_q;
	logic [ID_BITS-1:0] ch_id_q;
	logic [31:0]        ch_pay_q;
	res_t               res_q;

	// memory ports
	logic               heap_we;
	logic [SLOT_W-1:0]  heap_waddr, heap_raddr_a, heap_raddr_b;
	logic [ENT_W-1:0]   heap_wdata, heap_rdata_a, heap_rdata_b;
	logic               map_we;
	logic [ID_BITS-1:0] map_waddr, map_raddr;
	logic [SLOT_W-1:0]  map_wdata, map_rdata;

	// heap entry fields as read
	logic signed [31:0] a_key, b_key;
	logic [ID_BITS-1:0] a_id, b_id;
	logic [31:0]        a_pay, b_pay;

	// compare unit operands
	logic signed [31:0] cmp_a, cmp_b;
	logic               cmp_gt;

	// child addressing for sift down
	logic [SLOT_W:0]    c_wide;
	logic [SLOT_W-1:0]  c_lo, c_inc;
	logic               c_in_heap, c_has_right, pick_b;
	logic [ID_BITS-1:0] req_id_idx;

	assign a_key = heap_rdata_a[ENT_W-1 -: 32];
	assign a_id  = heap_rdata_a[32 +: ID_BITS];
	assign a_pay = heap_rdata_a[31:0];
	assign b_key = heap_rdata_b[ENT_W-1 -: 32];
	assign b_id  = heap_rdata_b[32 +: ID_BITS];
	assign b_pay = heap_rdata_b[31:0];

	assign req_id_idx  = ID_BITS'(req.id);
	assign c_wide      = {pos_q, 1'b0};
	assign c_lo        = c_wide[SLOT_W-1:0];
	assign c_inc       = c_lo + 1'b1;
	assign c_in_heap   = (c_wide <= {1'b0, cnt_q});
	assign c_has_right = (c_wide < {1'b0, cnt_q});
	assign pick_b      = cmp_gt && c_has_right;

	imhq_heap_ram #(
		.DEPTH (CAPACITY + 1),
		.ADDR_W(SLOT_W),
		.DATA_W(ENT_W)
	) u_heap (
		.clk    (clk),
		.we     (heap_we),
		.waddr  (heap_waddr),
		.wdata  (heap_wdata),
		.raddr_a(heap_raddr_a),
		.raddr_b(heap_raddr_b),
		.rdata_a(heap_rdata_a),
		.rdata_b(heap_rdata_b)
	);

	imhq_map_ram #(
		.ADDR_W(ID_BITS),
		.DATA_W(SLOT_W)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	imhq_key_cmp u_cmp (
		.a (cmp_a),
		.b (cmp_b),
		.gt(cmp_gt)
	);

	// compare operand select
	always_comb begin
		cmp_a = cur_key_q;
		cmp_b = cur_key_q;
		unique case (state_q)
			S_SK_RD: begin
				cmp_a = cur_key_q;
				cmp_b = a_key;
			end
			S_RM_RD: begin
				cmp_a = b_key;
				cmp_b = a_key;
			end
			S_UP_CMP: begin
				cmp_a = a_key;
				cmp_b = cur_key_q;
			end
			S_DN_CH: begin
				cmp_a = a_key;
				cmp_b = b_key;
			end
			S_DN_CMP: begin
				cmp_a = cur_key_q;
				cmp_b = ch_key_q;
			end
			default: begin
				cmp_a = cur_key_q;
				cmp_b = cur_key_q;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		res_valid    = 1'b0;
		heap_we      = 1'b0;
		heap_waddr   = pos_q;
		heap_wdata   = {cur_key_q, cur_id_q, cur_pay_q};
		heap_raddr_a = pos_q;
		heap_raddr_b = cnt_q;
		map_we       = 1'b0;
		map_waddr    = cur_id_q;
		map_wdata    = pos_q;
		map_raddr    = req_id_idx;
		unique case (state_q)
			S_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = '0;
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				state_d = S_RESP;
				unique case (cmd_q)
					CMD_INSERT: begin
						if (cnt_q < SLOT_W'(CAPACITY) && map_rdata == '0) begin
							state_d = S_UP_RD;
						end
					end
					CMD_SET_KEY: begin
						heap_raddr_a = map_rdata;
						if (map_rdata != '0) begin
							state_d = S_SK_RD;
						end
					end
					CMD_DEL_MIN: begin
						heap_raddr_a = SLOT_W'(1);
						heap_raddr_b = cnt_q;
						if (cnt_q != '0) begin
							state_d = S_DM_RD;
						end
					end
					default: begin
						heap_raddr_a = map_rdata;
						heap_raddr_b = cnt_q;
						if (map_rdata != '0) begin
							state_d = S_RM_RD;
						end
					end
				endcase
			end
			S_SK_RD: begin
				state_d = cmp_gt ? S_DN_RD : S_UP_RD;
			end
			S_DM_RD: begin
				map_we    = 1'b1;
				map_waddr = a_id;
				map_wdata = '0;
				state_d   = (cnt_q > SLOT_W'(1)) ? S_DN_RD : S_RESP;
			end
			S_RM_RD: begin
				map_we    = 1'b1;
				map_waddr = cur_id_q;
				map_wdata = '0;
				if (pos_q != cnt_q) begin
					state_d = cmp_gt ? S_DN_RD : S_UP_RD;
				end else begin
					state_d = S_RESP;
				end
			end
			S_UP_RD: begin
				heap_raddr_a = pos_q >> 1;
				state_d      = (pos_q > SLOT_W'(1)) ? S_UP_CMP : S_FIN;
			end
			S_UP_CMP: begin
				if (cmp_gt) begin
					heap_we    = 1'b1;
					heap_wdata = heap_rdata_a;
					map_we     = 1'b1;
					map_waddr  = a_id;
					state_d    = S_UP_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DN_RD: begin
				heap_raddr_a = c_lo;
				heap_raddr_b = c_has_right ? c_inc : c_lo;
				state_d      = c_in_heap ? S_DN_CH : S_FIN;
			end
			S_DN_CH: begin
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (cmp_gt) begin
					heap_we    = 1'b1;
					heap_wdata = {ch_key_q, ch_id_q, ch_pay_q};
					map_we     = 1'b1;
					map_waddr  = ch_id_q;
					state_d    = S_DN_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				heap_we = 1'b1;
				map_we  = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: clr_q <= clr_q + 1'b1;
				S_LOOKUP: begin
					if (cmd_q == CMD_INSERT && cnt_q < SLOT_W'(CAPACITY) && map_rdata == '0) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DM_RD: cnt_q <= cnt_q - 1'b1;
				S_RM_RD: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd_q     <= req.command;
					cur_key_q <= req.key;
					cur_id_q  <= req_id_idx;
					cur_pay_q <= req.payload;
					res_q     <= '{status: STS_OK, out_id: '0, out_key: '0, out_payload: '0};
				end
			end
			S_LOOKUP: begin
				unique case (cmd_q)
					CMD_INSERT: begin
						pos_q <= cnt_q + 1'b1;
						if (cnt_q >= SLOT_W'(CAPACITY)) begin
							res_q.status <= STS_FULL;
						end else if (map_rdata != '0) begin
							res_q.status <= STS_DUPLICATE;
						end
					end
					CMD_DEL_MIN: begin
						pos_q <= SLOT_W'(1);
						if (cnt_q == '0) begin
							res_q.status <= STS_EMPTY;
						end
					end
					default: begin
						pos_q <= map_rdata;
						if (map_rdata == '0) begin
							res_q.status <= STS_NOT_FOUND;
						end
					end
				endcase
			end
			S_SK_RD: begin
				cur_id_q  <= a_id;
				cur_pay_q <= a_pay;
			end
			S_DM_RD: begin
				res_q.out_id      <= 8'(a_id);
				res_q.out_key     <= a_key;
				res_q.out_payload <= a_pay;
				cur_key_q         <= b_key;
				cur_id_q          <= b_id;
				cur_pay_q         <= b_pay;
			end
			S_RM_RD: begin
				res_q.out_id      <= 8'(cur_id_q);
				res_q.out_key     <= a_key;
				res_q.out_payload <= a_pay;
				cur_key_q         <= b_key;
				cur_id_q          <= b_id;
				cur_pay_q         <= b_pay;
			end
			S_UP_CMP: begin
				if (cmp_gt) begin
					pos_q <= pos_q >> 1;
				end
			end
			S_DN_CH: begin
				ch_key_q <= pick_b ? b_key : a_key;
				ch_id_q  <= pick_b ? b_id : a_id;
				ch_pay_q <= pick_b ? b_pay : a_pay;
				csel_q   <= pick_b ? c_inc : c_lo;
			end
			S_DN_CMP: begin
				if (cmp_gt) begin
					pos_q <= csel_q;
				end
			end
			default: ;
		endcase
	end

	assign res = res_q;

	// checks
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && res_valid))
		else $error("request and result handshakes open together");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SLOT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> req_ready)
		else $error("not idle after result taken");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		heap_we |-> (heap_waddr != '0 && heap_waddr <= cnt_q))
		else $error("heap write outside live slots");

endmodule
